// ----- design/cpu_load_from_tick_counters_core_defines.svh -----
// Assertion macros shared by the core load block.
`ifndef CPU_LOAD_FROM_TICK_COUNTERS_CORE_DEFINES_SVH
`define CPU_LOAD_FROM_TICK_COUNTERS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cltc_pkg.sv -----
// Shared constants for the core load block.
package cltc_pkg;

    localparam int MAX_CORES_DEF = 64;
    localparam int NUM_TICKS     = 8;
    localparam int TICK_W        = 32;
    localparam int ACTIVE_W      = 7;
    localparam int INDEX_W       = 6;
    localparam int LOAD_W        = 14;
    localparam int PROD_W        = TICK_W + LOAD_W;
    localparam int LOAD_SCALE    = 10000;
    localparam int LOAD_MAX      = 10000;

    // Tick slots that form the idle figure.
    localparam int IDLE_SLOT     = 3;
    localparam int IOWAIT_SLOT   = 4;

endpackage

// ----- design/cltc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module cltc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cpu_load_from_tick_counters_core.sv -----
// Per-core busy share from cumulative tick counters, with a per-frame mean.
// Items are taken one at a time: o_ready is high only in idle, after the previous result has been
// loaded into the output register. Zero or inverted differences skip the divider; a frame's last
// core also runs the frame mean. The work is an eight-step tick sum and a restoring divider of
// 14 steps per core load, which is shared with the frame mean and forms it one bit per cycle.
// Reset: synchronous, clears the per-core valid bits (history reads as zero), the core
// counter, the load sum and sets active_cores to 1; no memory clearing pass is needed.
`include "cpu_load_from_tick_counters_core_defines.svh"

module cpu_load_from_tick_counters_core #(
    parameter int MAX_CORES = cltc_pkg::MAX_CORES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cltc_pkg::ACTIVE_W-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cltc_pkg::TICK_W-1:0]   i_user_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_nice_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_system_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_idle_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_iowait_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_irq_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_softirq_ticks,
    input  logic [cltc_pkg::TICK_W-1:0]   i_steal_ticks,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cltc_pkg::INDEX_W-1:0]  o_core_index,
    output logic [cltc_pkg::LOAD_W-1:0]   o_core_load,
    output logic                          o_frame_end,
    output logic [cltc_pkg::LOAD_W-1:0]   o_average_load
);

    import cltc_pkg::*;

    localparam int SLOT_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNT_W  = $clog2(MAX_CORES + 1);
    localparam int NW     = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
    localparam int SUM_W  = $clog2(MAX_CORES * LOAD_SCALE + 1);
    localparam int QW     = (SUM_W > LOAD_W) ? SUM_W : LOAD_W;
    localparam int IT_W   = $clog2(QW + 1);
    localparam int STEP_W = $clog2(NUM_TICKS);
    localparam int HIST_W = 2 * TICK_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIFF,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_LOAD,
        ST_AVG,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [ACTIVE_W-1:0]   r_active;
    logic [SLOT_W-1:0]     r_core_cnt;
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_sum;
    logic [MAX_CORES-1:0]  r_vld;
    logic [TICK_W-1:0]     r_tick [NUM_TICKS];
    logic [STEP_W-1:0]     r_step;
    logic [TICK_W-1:0]     r_acc;
    logic [TICK_W-1:0]     r_idle;
    logic [TICK_W-1:0]     r_tdiff;
    logic [TICK_W-1:0]     r_idiff;
    logic [TICK_W-1:0]     r_busy;
    logic [TICK_W-1:0]     r_rem;
    logic [QW-1:0]         r_quo;
    logic [TICK_W-1:0]     r_dsr;
    logic [IT_W-1:0]       r_iter;
    logic [LOAD_W-1:0]     r_load;
    logic                  r_last;
    logic                  r_out_valid;
    logic [INDEX_W-1:0]    r_out_index;
    logic [LOAD_W-1:0]     r_out_load;
    logic                  r_out_end;
    logic [LOAD_W-1:0]     r_out_avg;

    logic [HIST_W-1:0]     ram_rdata;
    logic                  ram_we;
    logic [TICK_W-1:0]     prev_total;
    logic [TICK_W-1:0]     prev_idle;
    logic [NW-1:0]         act_ext;
    logic [CNT_W-1:0]      n_eff;
    logic                  is_last;
    logic [LOAD_W-1:0]     cur_load;
    logic [SUM_W-1:0]      n_sum;
    logic [PROD_W-1:0]     product;
    logic [TICK_W:0]       n_shift;
    logic                  n_ge;
    logic [TICK_W-1:0]     n_rem;
    logic [QW-1:0]         n_quo;
    logic [LOAD_W-1:0]     avg_sat;

    // Per-core history: {total, idle} of the previous sample.
    cltc_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_CORES),
        .AW    (SLOT_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_core_cnt),
        .i_wdata ({r_acc, r_idle}),
        .i_raddr (r_core_cnt),
        .o_rdata (ram_rdata)
    );

    assign ram_we = (r_state == ST_DIFF);

    // An entry never written since reset reads as zero.
    assign prev_total = r_vld[r_core_cnt] ? ram_rdata[HIST_W-1:TICK_W] : '0;
    assign prev_idle  = r_vld[r_core_cnt] ? ram_rdata[TICK_W-1:0] : '0;

    always_comb begin
        act_ext = NW'(r_active);
        if (act_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (act_ext > NW'(MAX_CORES)) begin
            n_eff = CNT_W'(MAX_CORES);
        end else begin
            n_eff = CNT_W'(act_ext);
        end
    end

    assign is_last  = (CNT_W'(r_core_cnt) + CNT_W'(1)) >= n_eff;
    assign cur_load = r_quo[LOAD_W-1:0];
    assign n_sum    = r_sum + SUM_W'(cur_load);
    assign product  = PROD_W'(r_busy) * PROD_W'(LOAD_SCALE);

    // Shared restoring divider step: one quotient bit per cycle.
    assign n_shift = {r_rem, r_quo[QW-1]};
    assign n_ge    = n_shift >= {1'b0, r_dsr};
    assign n_rem   = n_ge ? TICK_W'(n_shift - {1'b0, r_dsr}) : n_shift[TICK_W-1:0];
    assign n_quo   = {r_quo[QW-2:0], n_ge};

    assign avg_sat = (r_quo > QW'(LOAD_MAX)) ? LOAD_W'(LOAD_MAX) : r_quo[LOAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= ACTIVE_W'(1);
            r_core_cnt  <= '0;
            r_sum       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            // A finished item loads the output register once it is free or being emptied.
            if (r_state == ST_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_tick[0] <= i_user_ticks;
                        r_tick[1] <= i_nice_ticks;
                        r_tick[2] <= i_system_ticks;
                        r_tick[3] <= i_idle_ticks;
                        r_tick[4] <= i_iowait_ticks;
                        r_tick[5] <= i_irq_ticks;
                        r_tick[6] <= i_softirq_ticks;
                        r_tick[7] <= i_steal_ticks;
                        r_idle    <= i_idle_ticks + i_iowait_ticks;
                        r_acc     <= '0;
                        r_step    <= '0;
                        r_state   <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_acc  <= r_acc + r_tick[r_step];
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(NUM_TICKS - 1)) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_tdiff <= (r_acc > prev_total) ? (r_acc - prev_total) : '0;
                    r_idiff <= (r_idle > prev_idle) ? (r_idle - prev_idle) : '0;
                    r_vld[r_core_cnt] <= 1'b1;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_tdiff == '0 || r_idiff > r_tdiff) begin
                        r_quo   <= '0;
                        r_state <= ST_LOAD;
                    end else begin
                        r_busy  <= r_tdiff - r_idiff;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // The quotient fits in LOAD_W bits, so the upper product bits
                    // seed the remainder and only LOAD_W steps are needed.
                    r_rem   <= product[PROD_W-1:LOAD_W];
                    r_quo   <= QW'(product[LOAD_W-1:0]) << (QW - LOAD_W);
                    r_dsr   <= r_tdiff;
                    r_iter  <= IT_W'(LOAD_W);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_iter <= r_iter - IT_W'(1);
                    if (r_iter == IT_W'(1)) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_load <= cur_load;
                    r_slot <= r_core_cnt;
                    r_last <= is_last;
                    if (is_last) begin
                        r_rem      <= '0;
                        r_quo      <= QW'(n_sum);
                        r_dsr      <= TICK_W'(n_eff);
                        r_iter     <= IT_W'(QW);
                        r_sum      <= '0;
                        r_core_cnt <= '0;
                        r_state    <= ST_AVG;
                    end else begin
                        r_sum      <= n_sum;
                        r_core_cnt <= r_core_cnt + SLOT_W'(1);
                        r_state    <= ST_DONE;
                    end
                end
                ST_AVG: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_iter <= r_iter - IT_W'(1);
                    if (r_iter == IT_W'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Wait until the output register is free or being emptied.
                    if (!r_out_valid || i_ready) begin
                        r_out_index <= INDEX_W'(r_slot);
                        r_out_load  <= r_load;
                        r_out_end   <= r_last;
                        r_out_avg   <= r_last ? avg_sat : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_core_index   = r_out_index;
    assign o_core_load    = r_out_load;
    assign o_frame_end    = r_out_end;
    assign o_average_load = r_out_avg;

    `CLTC_ASSERT_NOW(a_div_rem_below_divisor, i_clk, i_rst_n,
        (r_state == ST_DIV || r_state == ST_AVG), (r_rem < r_dsr),
        "divider remainder reached the divisor")
    `CLTC_ASSERT_NOW(a_load_in_range, i_clk, i_rst_n,
        o_valid, (o_core_load <= LOAD_W'(LOAD_MAX) && o_average_load <= LOAD_W'(LOAD_MAX)),
        "load result above full scale")
    `CLTC_ASSERT_NOW(a_avg_only_at_frame_end, i_clk, i_rst_n,
        (o_valid && !o_frame_end), (o_average_load == '0),
        "average given on a core that does not end the frame")
    `CLTC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        (i_valid && o_ready), (!o_ready && r_state == ST_SUM),
        "item accepted but summation did not start")

endmodule
